### hw/rtl/event_flag_group_unit_top_macros.svh
// assertion macros for the event flag group unit
`ifndef EVENT_FLAG_GROUP_UNIT_TOP_MACROS_SVH
`define EVENT_FLAG_GROUP_UNIT_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// checked outside reset only
`define EFG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define EFG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define EFG_ASSERT(label, prop, msg)
`define EFG_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

### hw/rtl/efg_pkg.sv
// shared types and constants for the event flag group unit
`default_nettype none

package efg_pkg;

    localparam int WAITERS   = 16;
    localparam int FLAG_BITS = 32;
    localparam int TID_W     = 4;
    localparam int MODE_W    = 3;
    localparam int CNT_W     = $clog2(WAITERS + 1);
    localparam int ADDR_W    = (WAITERS > 1) ? $clog2(WAITERS) : 1;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_PAD_W  = OUT_DATA_W - (TID_W + 2 * FLAG_BITS + CNT_W);

    localparam logic [CNT_W-1:0] WAITERS_CNT = WAITERS[CNT_W-1:0];

    // wait mode bit positions
    localparam int MODE_SET = 0;
    localparam int MODE_ALL = 1;
    localparam int MODE_EAT = 2;

    typedef enum logic [1:0] {
        ACT_WAIT    = 2'd0,
        ACT_POLL    = 2'd1,
        ACT_NOTIFY  = 2'd2,
        ACT_DESTROY = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_UNMET   = 3'd1,
        ST_DELETED = 3'd2,
        ST_FULL    = 3'd3,
        ST_DONE    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        EFG_IDLE,
        EFG_WALK,
        EFG_DEL
    } efg_state_t;

    typedef struct packed {
        logic [TID_W-1:0]     tid;
        logic [MODE_W-1:0]    mode;
        logic [FLAG_BITS-1:0] mask;
    } waiter_t;

    typedef struct packed {
        logic                 ok;
        logic [FLAG_BITS-1:0] matched;
        logic [FLAG_BITS-1:0] flags_after;
    } match_t;

endpackage

`default_nettype wire

### hw/rtl/efg_match.sv
// shared match and consume unit
`default_nettype none

module efg_match (
    input  wire logic [efg_pkg::MODE_W-1:0]    mode,
    input  wire logic [efg_pkg::FLAG_BITS-1:0] mask,
    input  wire logic [efg_pkg::FLAG_BITS-1:0] flags,
    output efg_pkg::match_t                    res
);

    logic [efg_pkg::FLAG_BITS-1:0] cal;
    logic                          ok;

    always_comb
    begin
        cal = mode[efg_pkg::MODE_SET] ? (flags & mask) : (~flags & mask);
        ok  = mode[efg_pkg::MODE_ALL] ? (cal == mask) : (|cal);

        res.ok          = ok;
        res.matched     = cal;
        res.flags_after = flags;
        // consuming flips the matched bits to the opposite state
        if (ok && mode[efg_pkg::MODE_EAT])
        begin
            if (mode[efg_pkg::MODE_SET])
                res.flags_after = flags & ~mask;
            else
                res.flags_after = flags | mask;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/efg_table.sv
// waiter table: one write port, one registered read port
`default_nettype none

module efg_table (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [efg_pkg::ADDR_W-1:0]  wr_addr,
    input  efg_pkg::waiter_t                 wr_data,
    input  wire logic [efg_pkg::ADDR_W-1:0]  rd_addr,
    output efg_pkg::waiter_t                 rd_data
);

    efg_pkg::waiter_t mem_reg [efg_pkg::WAITERS];
    efg_pkg::waiter_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/event_flag_group_unit_top.sv
// top level of the event flag group unit: sequencer, flag word and result register
`default_nettype none

`include "event_flag_group_unit_top_macros.svh"

// Event flag group: a 32-bit flag word plus an ordered table of up to 16 waiting
// tasks. Wait and poll beats are checked at the accepting edge, and their single
// result beat shows on the next cycle; a new beat can be taken while the last
// result is shown if the result side takes it. Notify walks the waiter table one
// entry per cycle through the single match/consume unit and destroy walks it
// without matching; a granted or deleted entry waits while the result side
// stalls. Both then give a summary beat with tlast set; s_axis_tready stays low
// during a walk.
// Writing cfg_wr_data loads the flag word directly; waiters are kept.
module event_flag_group_unit_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // task_id[3:0], wait_mode[6:4], mask[38:7], set_bits[39]
    input  wire logic [efg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]                        s_axis_tuser,
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // out_task_id[3:0], result_flags[35:4], flag_word[67:36], waiter_count[72:68], zero pad
    output      logic [efg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status[2:0]
    output      logic [2:0]                        m_axis_tuser,
    output      logic                              m_axis_tlast,
    input  wire logic                              cfg_wr_en,
    input  wire logic [efg_pkg::FLAG_BITS-1:0]     cfg_wr_data
);

    efg_pkg::efg_state_t state_reg, state_next;

    logic [efg_pkg::FLAG_BITS-1:0] flags_reg, flags_next;
    logic [efg_pkg::CNT_W-1:0]     total_reg, total_next;
    logic [efg_pkg::CNT_W-1:0]     idx_reg, idx_next;
    logic [efg_pkg::CNT_W-1:0]     w_reg, w_next;

    logic                          o_valid_reg, o_valid_next;
    logic [efg_pkg::TID_W-1:0]     o_tid_reg, o_tid_next;
    efg_pkg::status_t              o_status_reg, o_status_next;
    logic [efg_pkg::FLAG_BITS-1:0] o_rf_reg, o_rf_next;
    logic [efg_pkg::FLAG_BITS-1:0] o_fw_reg, o_fw_next;
    logic [efg_pkg::CNT_W-1:0]     o_cnt_reg, o_cnt_next;
    logic                          o_last_reg, o_last_next;

    logic [efg_pkg::TID_W-1:0]     in_tid;
    logic [efg_pkg::MODE_W-1:0]    in_mode;
    logic [efg_pkg::FLAG_BITS-1:0] in_mask;
    logic                          in_setb;
    efg_pkg::action_t              in_act;

    logic                          out_ok;
    logic                          accept;
    logic                          at_end;

    logic [efg_pkg::MODE_W-1:0]    mu_mode;
    logic [efg_pkg::FLAG_BITS-1:0] mu_mask;
    efg_pkg::match_t               mres;

    logic                          tbl_we;
    logic [efg_pkg::ADDR_W-1:0]    tbl_waddr;
    efg_pkg::waiter_t              tbl_wdata;
    logic [efg_pkg::ADDR_W-1:0]    tbl_raddr;
    efg_pkg::waiter_t              entry;

    assign in_tid  = s_axis_tdata[3:0];
    assign in_mode = s_axis_tdata[6:4];
    assign in_mask = s_axis_tdata[38:7];
    assign in_setb = s_axis_tdata[39];
    assign in_act  = efg_pkg::action_t'(s_axis_tuser);

    assign out_ok        = !o_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == efg_pkg::EFG_IDLE) && out_ok;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign at_end        = (idx_reg == total_reg);

    // the match unit serves the input beat when idle and table entries during a walk
    assign mu_mode = (state_reg == efg_pkg::EFG_WALK) ? entry.mode : in_mode;
    assign mu_mask = (state_reg == efg_pkg::EFG_WALK) ? entry.mask : in_mask;

    efg_match u_match (
        .mode  (mu_mode),
        .mask  (mu_mask),
        .flags (flags_reg),
        .res   (mres)
    );

    // read address follows the next index so the entry is ready when the walk reaches it
    assign tbl_raddr = (idx_next < efg_pkg::WAITERS_CNT) ?
                       idx_next[efg_pkg::ADDR_W-1:0] : '0;

    efg_table u_table (
        .clk     (clk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_addr (tbl_raddr),
        .rd_data (entry)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            efg_pkg::EFG_IDLE:
            begin
                if (accept && in_act == efg_pkg::ACT_NOTIFY)
                    state_next = efg_pkg::EFG_WALK;
                else if (accept && in_act == efg_pkg::ACT_DESTROY)
                    state_next = efg_pkg::EFG_DEL;
            end
            efg_pkg::EFG_WALK,
            efg_pkg::EFG_DEL:
            begin
                if (at_end && out_ok)
                    state_next = efg_pkg::EFG_IDLE;
            end
            default:
                state_next = efg_pkg::EFG_IDLE;
        endcase
    end

    always_comb
    begin
        flags_next    = flags_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        w_next        = w_reg;
        o_valid_next  = o_valid_reg && !m_axis_tready;
        o_tid_next    = o_tid_reg;
        o_status_next = o_status_reg;
        o_rf_next     = o_rf_reg;
        o_fw_next     = o_fw_reg;
        o_cnt_next    = o_cnt_reg;
        o_last_next   = o_last_reg;
        tbl_we        = 1'b0;
        tbl_waddr     = total_reg[efg_pkg::ADDR_W-1:0];
        tbl_wdata     = '{tid: in_tid, mode: in_mode, mask: in_mask};

        case (state_reg)
            efg_pkg::EFG_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    case (in_act)
                        efg_pkg::ACT_WAIT:
                        begin
                            o_valid_next = 1'b1;
                            o_tid_next   = in_tid;
                            o_rf_next    = mres.matched;
                            o_last_next  = 1'b1;
                            o_cnt_next   = total_reg;
                            if (mres.ok)
                            begin
                                flags_next    = mres.flags_after;
                                o_status_next = efg_pkg::ST_GRANTED;
                            end
                            else if (total_reg < efg_pkg::WAITERS_CNT)
                            begin
                                tbl_we        = 1'b1;
                                total_next    = total_reg + 1'b1;
                                o_cnt_next    = total_reg + 1'b1;
                                o_status_next = efg_pkg::ST_UNMET;
                            end
                            else
                            begin
                                o_status_next = efg_pkg::ST_FULL;
                            end
                            o_fw_next = mres.ok ? mres.flags_after : flags_reg;
                        end
                        efg_pkg::ACT_POLL:
                        begin
                            flags_next    = mres.flags_after;
                            o_valid_next  = 1'b1;
                            o_tid_next    = in_tid;
                            o_status_next = mres.ok ? efg_pkg::ST_GRANTED : efg_pkg::ST_UNMET;
                            o_rf_next     = mres.matched;
                            o_fw_next     = mres.flags_after;
                            o_cnt_next    = total_reg;
                            o_last_next   = 1'b1;
                        end
                        efg_pkg::ACT_NOTIFY:
                        begin
                            flags_next = in_setb ? (flags_reg | in_mask) : (flags_reg & ~in_mask);
                            w_next     = '0;
                        end
                        efg_pkg::ACT_DESTROY:
                        begin
                            w_next = '0;
                        end
                        default:
                        begin
                            w_next = w_reg;
                        end
                    endcase
                end
            end

            efg_pkg::EFG_WALK:
            begin
                if (at_end)
                begin
                    if (out_ok)
                    begin
                        total_next    = w_reg;
                        o_valid_next  = 1'b1;
                        o_tid_next    = '0;
                        o_status_next = efg_pkg::ST_DONE;
                        o_rf_next     = '0;
                        o_fw_next     = flags_reg;
                        o_cnt_next    = w_reg;
                        o_last_next   = 1'b1;
                    end
                end
                else if (mres.ok)
                begin
                    if (out_ok)
                    begin
                        flags_next    = mres.flags_after;
                        idx_next      = idx_reg + 1'b1;
                        o_valid_next  = 1'b1;
                        o_tid_next    = entry.tid;
                        o_status_next = efg_pkg::ST_GRANTED;
                        o_rf_next     = mres.matched;
                        o_fw_next     = mres.flags_after;
                        // waiters left: removals so far, this one included, come off
                        o_cnt_next    = total_reg + w_reg - idx_reg - 1'b1;
                        o_last_next   = 1'b0;
                    end
                end
                else
                begin
                    // keep the entry, compacting toward the front
                    tbl_we    = 1'b1;
                    tbl_waddr = w_reg[efg_pkg::ADDR_W-1:0];
                    tbl_wdata = entry;
                    w_next    = w_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end

            efg_pkg::EFG_DEL:
            begin
                if (out_ok)
                begin
                    o_valid_next = 1'b1;
                    o_rf_next    = '0;
                    o_fw_next    = flags_reg;
                    if (at_end)
                    begin
                        total_next    = '0;
                        o_tid_next    = '0;
                        o_status_next = efg_pkg::ST_DONE;
                        o_cnt_next    = '0;
                        o_last_next   = 1'b1;
                    end
                    else
                    begin
                        idx_next      = idx_reg + 1'b1;
                        o_tid_next    = entry.tid;
                        o_status_next = efg_pkg::ST_DELETED;
                        o_cnt_next    = total_reg - idx_reg - 1'b1;
                        o_last_next   = 1'b0;
                    end
                end
            end

            default:
            begin
                idx_next = '0;
            end
        endcase

        if (cfg_wr_en)
            flags_next = cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= efg_pkg::EFG_IDLE;
            flags_reg   <= '0;
            total_reg   <= '0;
            idx_reg     <= '0;
            w_reg       <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            flags_reg   <= flags_next;
            total_reg   <= total_next;
            idx_reg     <= idx_next;
            w_reg       <= w_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_tid_reg    <= o_tid_next;
        o_status_reg <= o_status_next;
        o_rf_reg     <= o_rf_next;
        o_fw_reg     <= o_fw_next;
        o_cnt_reg    <= o_cnt_next;
        o_last_reg   <= o_last_next;
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {{efg_pkg::OUT_PAD_W{1'b0}}, o_cnt_reg, o_fw_reg, o_rf_reg, o_tid_reg};
    assign m_axis_tuser  = o_status_reg;
    assign m_axis_tlast  = o_last_reg;

    `EFG_ASSERT_ALWAYS(a_total_bound, total_reg <= efg_pkg::WAITERS_CNT, "waiter count past table size")
    `EFG_ASSERT(a_walk_compact, (state_reg == efg_pkg::EFG_WALK) |-> (w_reg <= idx_reg), "compaction index ahead of walk")
    `EFG_ASSERT(a_walk_index, (state_reg != efg_pkg::EFG_IDLE) |-> (idx_reg <= total_reg), "walk index past waiter count")
    `EFG_ASSERT(a_notify_walks, (accept && in_act == efg_pkg::ACT_NOTIFY) |=> (state_reg == efg_pkg::EFG_WALK), "notify did not start a walk")
    `EFG_ASSERT(a_last_idle, (m_axis_tvalid && m_axis_tlast) |-> (state_reg == efg_pkg::EFG_IDLE), "final beat shown while walking")

endmodule

`default_nettype wire

### test/tb_top.sv
// testbench for the event flag group unit: stream driver, predictor and result checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 1_500_000;

    localparam logic [efg_pkg::MODE_W-1:0] M_SET = 3'b001 << efg_pkg::MODE_SET;
    localparam logic [efg_pkg::MODE_W-1:0] M_ALL = 3'b001 << efg_pkg::MODE_ALL;
    localparam logic [efg_pkg::MODE_W-1:0] M_EAT = 3'b001 << efg_pkg::MODE_EAT;

    typedef struct {
        logic [efg_pkg::TID_W-1:0]     tid;
        efg_pkg::status_t              status;
        logic [efg_pkg::FLAG_BITS-1:0] hits;
        logic [efg_pkg::FLAG_BITS-1:0] flags;
        logic [efg_pkg::CNT_W-1:0]     count;
        logic                          last;
    } flag_result_t;

    class flag_group_scoreboard;
        logic [efg_pkg::FLAG_BITS-1:0] flags;
        efg_pkg::waiter_t              sleepers[$];
        flag_result_t                  owed_results[$];
        int                            mismatches;

        function new();
            flags = '0;
            mismatches = 0;
        endfunction

        function void load_flags(logic [efg_pkg::FLAG_BITS-1:0] value);
            flags = value;
        endfunction

        function int owed();
            return owed_results.size();
        endfunction

        // evaluate a request against the flag word, consuming on a match
        function bit try_match(logic [efg_pkg::MODE_W-1:0] mode,
                               logic [efg_pkg::FLAG_BITS-1:0] mask,
                               output logic [efg_pkg::FLAG_BITS-1:0] hits);
            bit ok;
            hits = mode[efg_pkg::MODE_SET] ? (flags & mask) : (~flags & mask);
            ok = mode[efg_pkg::MODE_ALL] ? (hits == mask) : (hits != '0);
            if (ok && mode[efg_pkg::MODE_EAT])
                flags = mode[efg_pkg::MODE_SET] ? (flags & ~mask) : (flags | mask);
            return ok;
        endfunction

        function void owe(logic [efg_pkg::TID_W-1:0] tid, efg_pkg::status_t st,
                          logic [efg_pkg::FLAG_BITS-1:0] hits, int count, logic last);
            flag_result_t r;
            r.tid = tid;
            r.status = st;
            r.hits = hits;
            r.flags = flags;
            r.count = count[efg_pkg::CNT_W-1:0];
            r.last = last;
            owed_results.push_back(r);
        endfunction

        function void apply_request(efg_pkg::action_t act, logic [efg_pkg::TID_W-1:0] tid,
                                    logic [efg_pkg::MODE_W-1:0] mode,
                                    logic [efg_pkg::FLAG_BITS-1:0] mask, logic setb);
            logic [efg_pkg::FLAG_BITS-1:0] hits;
            efg_pkg::waiter_t              kept[$];
            efg_pkg::waiter_t              w;
            int                            total;
            bit                            ok;
            total = sleepers.size();
            case (act)
                efg_pkg::ACT_WAIT:
                begin
                    if (try_match(mode, mask, hits))
                        owe(tid, efg_pkg::ST_GRANTED, hits, total, 1'b1);
                    else if (total < efg_pkg::WAITERS)
                    begin
                        w.tid = tid;
                        w.mode = mode;
                        w.mask = mask;
                        sleepers.push_back(w);
                        owe(tid, efg_pkg::ST_UNMET, hits, total + 1, 1'b1);
                    end
                    else
                        owe(tid, efg_pkg::ST_FULL, hits, total, 1'b1);
                end
                efg_pkg::ACT_POLL:
                begin
                    ok = try_match(mode, mask, hits);
                    owe(tid, ok ? efg_pkg::ST_GRANTED : efg_pkg::ST_UNMET, hits, total, 1'b1);
                end
                efg_pkg::ACT_NOTIFY:
                begin
                    flags = setb ? (flags | mask) : (flags & ~mask);
                    // count on a wake beat: survivors so far plus entries not yet walked
                    foreach (sleepers[i])
                    begin
                        if (try_match(sleepers[i].mode, sleepers[i].mask, hits))
                            owe(sleepers[i].tid, efg_pkg::ST_GRANTED, hits,
                                kept.size() + total - i - 1, 1'b0);
                        else
                            kept.push_back(sleepers[i]);
                    end
                    sleepers = kept;
                    owe('0, efg_pkg::ST_DONE, '0, kept.size(), 1'b1);
                end
                default:
                begin
                    foreach (sleepers[i])
                        owe(sleepers[i].tid, efg_pkg::ST_DELETED, '0, total - i - 1, 1'b0);
                    sleepers.delete();
                    owe('0, efg_pkg::ST_DONE, '0, 0, 1'b1);
                end
            endcase
        endfunction

        function void check_result(logic [efg_pkg::TID_W-1:0] tid, logic [2:0] st,
                                   logic [efg_pkg::FLAG_BITS-1:0] hits,
                                   logic [efg_pkg::FLAG_BITS-1:0] fword,
                                   logic [efg_pkg::CNT_W-1:0] count, logic last);
            flag_result_t e;
            if (owed_results.size() == 0)
            begin
                $error("unexpected result beat: task %0h status %0d", tid, st);
                mismatches++;
                return;
            end
            e = owed_results.pop_front();
            if (tid !== e.tid)
            begin
                $error("out_task_id: expected %0h, got %0h", e.tid, tid);
                mismatches++;
            end
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                mismatches++;
            end
            if (hits !== e.hits)
            begin
                $error("result_flags: expected %h, got %h", e.hits, hits);
                mismatches++;
            end
            if (fword !== e.flags)
            begin
                $error("flag_word: expected %h, got %h", e.flags, fword);
                mismatches++;
            end
            if (count !== e.count)
            begin
                $error("waiter_count: expected %0d, got %0d", e.count, count);
                mismatches++;
            end
            if (last !== e.last)
            begin
                $error("last: expected %0b, got %0b", e.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [efg_pkg::IN_DATA_W-1:0]     s_axis_tdata;
    logic [1:0]                        s_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [efg_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
    logic [2:0]                        m_axis_tuser;
    logic                              m_axis_tlast;
    logic                              cfg_wr_en;
    logic [efg_pkg::FLAG_BITS-1:0]     cfg_wr_data;

    flag_group_scoreboard sb;
    int  cycles = 0;
    bit  steady = 1'b0;
    bit  hold_out = 1'b0;

    event_flag_group_unit_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result beats are sampled with pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[3:0], m_axis_tuser, m_axis_tdata[35:4],
                            m_axis_tdata[67:36], m_axis_tdata[72:68], m_axis_tlast);
    end

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [efg_pkg::FLAG_BITS-1:0] pick_mask();
        int unsigned sel;
        logic [efg_pkg::FLAG_BITS-1:0] m;
        sel = $urandom_range(0, 9);
        m = '0;
        // mostly a few bits in a narrow window so requests collide and match
        if (sel < 5)
            repeat ($urandom_range(1, 3)) m[$urandom_range(0, 7)] = 1'b1;
        else if (sel < 7)
            m = $urandom & 32'h0000_00ff;
        else if (sel == 7)
            m = $urandom;
        else if (sel == 8)
            m = $urandom_range(0, 1) ? '1 : '0;
        else
            m = $urandom & $urandom;
        return m;
    endfunction

    // receiver: random stalls, a long hold-off on request, none in steady stretches
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_out)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_out = 1'b0;
            end
            else if (steady)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    task automatic send_item(efg_pkg::action_t act, logic [efg_pkg::TID_W-1:0] tid,
                             logic [efg_pkg::MODE_W-1:0] mode,
                             logic [efg_pkg::FLAG_BITS-1:0] mask, logic setb);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {setb, mask, mode, tid};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.apply_request(act, tid, mode, mask, setb);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.owed() != 0);
    endtask

    task automatic write_init_flags(logic [efg_pkg::FLAG_BITS-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        sb.load_flags(value);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(int count, bit with_hold, bit with_pause);
        int unsigned sel;
        efg_pkg::action_t act;
        for (int n = 0; n < count; n++)
        begin
            if (with_hold && n == count / 4)
                hold_out = 1'b1;
            if (with_pause && n == count / 2)
                drain();
            sel = $urandom_range(0, 99);
            if (sel < 40)
                act = efg_pkg::ACT_WAIT;
            else if (sel < 60)
                act = efg_pkg::ACT_POLL;
            else if (sel < 95)
                act = efg_pkg::ACT_NOTIFY;
            else
                act = efg_pkg::ACT_DESTROY;
            send_item(act, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), pick_mask(),
                      $urandom_range(0, 9) < 6);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= efg_pkg::ACT_WAIT;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_init_flags('0);
        // empty flags: any-set fails, empty mask fails under any, passes under all
        send_item(efg_pkg::ACT_POLL, 4'd1, M_SET, '1, 1'b0);
        send_item(efg_pkg::ACT_POLL, 4'd2, '0, '0, 1'b0);
        send_item(efg_pkg::ACT_POLL, 4'd3, M_ALL, '0, 1'b0);
        // all-clear wait with consume flips the whole word to ones
        send_item(efg_pkg::ACT_WAIT, 4'd4, M_ALL | M_EAT, '1, 1'b0);
        send_item(efg_pkg::ACT_NOTIFY, 4'd0, '0, 32'h0000_ffff, 1'b0);
        // fill the table, odd tasks consume so later waiters lose bit 31
        for (int i = 0; i < efg_pkg::WAITERS; i++)
            send_item(efg_pkg::ACT_WAIT, 4'(i), M_SET | M_ALL | ((i % 2) ? M_EAT : '0),
                      32'h8000_0000 | (32'h1 << i), 1'b0);
        send_item(efg_pkg::ACT_WAIT, 4'd15, M_SET | M_ALL | M_EAT, 32'h0000_0001, 1'b0);
        send_item(efg_pkg::ACT_NOTIFY, 4'd0, '0, 32'h0000_00ff, 1'b1);
        send_item(efg_pkg::ACT_POLL, 4'd15, M_SET | M_EAT, 32'h8000_0001, 1'b0);
        send_item(efg_pkg::ACT_DESTROY, 4'd0, '0, '0, 1'b0);
        send_item(efg_pkg::ACT_DESTROY, 4'd0, '0, '0, 1'b0);
        drain();

        steady = 1'b1;
        write_init_flags('1);
        run_random(85, 1'b0, 1'b0);
        drain();
        steady = 1'b0;

        write_init_flags($urandom);
        run_random(90, 1'b1, 1'b0);
        drain();

        write_init_flags('0);
        run_random(90, 1'b0, 1'b1);
        drain();

        write_init_flags($urandom);
        run_random(90, 1'b0, 1'b0);
        drain();

        repeat (40) @(posedge clk);
        if (sb.mismatches == 0 && sb.owed() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/efg_pkg.sv
hw/rtl/efg_match.sv
hw/rtl/efg_table.sv
hw/rtl/event_flag_group_unit_top.sv
test/tb_top.sv
